// ----- rtl/core/tcea_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcea_pkg
// Shared constants, codes, head tables and control structs for the
// track class evidence accumulator.
// ----------------------------------------------------------------------------
package tcea_pkg;

  localparam int MAX_TRACKS_DEF = 32;
  localparam int HEAD_SLOTS     = 26;   // 7 + 2 + 9 + 8 scores per track
  localparam int SCORE_W        = 32;
  localparam int TOT_W          = 36;   // sum of up to nine scores
  localparam int PROD_W         = 48;

  localparam logic [15:0] DECAY_RST = 16'd58982;
  localparam logic [15:0] MINF_RST  = 16'd3;

  // commands
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_BUMP   = 3'd1;
  localparam logic [2:0] CMD_VERD   = 3'd2;
  localparam logic [2:0] CMD_SHARES = 3'd3;
  localparam logic [2:0] CMD_REMOVE = 3'd4;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOEV     = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_TRACK = 2'd1;
  localparam logic [1:0] KIND_VERD  = 2'd2;
  localparam logic [1:0] KIND_SHARE = 2'd3;

  // config register indexes (paddr[2])
  localparam logic REG_DECAY = 1'b0;
  localparam logic REG_MINF  = 1'b1;

  function automatic logic [3:0] head_size(input logic [1:0] h);
    logic [3:0] r;
    case (h)
      2'd0:    r = 4'd7;
      2'd1:    r = 4'd2;
      2'd2:    r = 4'd9;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] head_base(input logic [1:0] h);
    logic [4:0] r;
    case (h)
      2'd0:    r = 5'd0;
      2'd1:    r = 5'd7;
      2'd2:    r = 5'd9;
      default: r = 5'd18;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic       load_in;
    logic       idx_clr;
    logic       idx_inc;
    logic       meta_rd;
    logic       meta_sel_slot;
    logic       cmp_step;
    logic       inval;
    logic       hit_take;
    logic       create;
    logic       clr_wr;
    logic       set_add_slot;
    logic       use_add_slot;
    logic       take_frames;
    logic       k_init_elem;
    logic       k_clr;
    logic       k_inc;
    logic       sc_rd;
    logic       mul;
    logic       sc_wr;
    logic       acc_clr;
    logic       acc_step;
    logic       frames_inc;
    logic       div_start;
    logic       div_sel_best;
    logic       out_load;
    logic [1:0] out_status;
    logic [1:0] out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       add_noop;
    logic       elem0;
    logic       elem_lt_cap;
    logic       sh_cnt_zero;
    logic       i_last;
    logic       clr_last;
    logic       hit;
    logic       free_any;
    logic       slot_ok;
    logic       k_cont;
    logic       sum_last;
    logic       total_zero;
    logic       sh_last;
    logic       div_busy;
    logic       rm_any;
    logic       out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] frames;
    logic        stable;
    logic [3:0]  best_index;
    logic [15:0] confidence;
    logic [3:0]  class_index;
    logic [15:0] share;
    logic        last_result;
  } res_t;

endpackage

// ----- rtl/core/tcea_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcea_if
// Item channels: command input and result output, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcea_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] obj_id;
  logic [1:0]  head;
  logic [3:0]  element_index;
  logic [15:0] prob;
  logic [3:0]  count;

  modport source(output valid, command, obj_id, head, element_index, prob, count,
                 input ready);
  modport sink(input valid, command, obj_id, head, element_index, prob, count,
               output ready);
endinterface

interface tcea_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] frames;
  logic        stable;
  logic [3:0]  best_index;
  logic [15:0] confidence;
  logic [3:0]  class_index;
  logic [15:0] share;
  logic        last_result;

  modport source(output valid, status, frames, stable, best_index, confidence,
                 class_index, share, last_result, input ready);
  modport sink(input valid, status, frames, stable, best_index, confidence,
               class_index, share, last_result, output ready);
endinterface

// ----- rtl/core/tcea_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcea_div
// Restoring divider, one quotient bit per cycle: (num << 16) / den,
// saturated to 16 bits. Requires num <= den.
// ----------------------------------------------------------------------------
module tcea_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tcea_pkg::SCORE_W-1:0] num,
  input  logic [tcea_pkg::TOT_W-1:0]  den,
  output logic                        busy,
  output logic [15:0]                 quo
);
  import tcea_pkg::*;

  logic               busy_r;
  logic [4:0]         cnt_r;
  logic [TOT_W:0]     rem_r;
  logic [TOT_W-1:0]   den_r;
  logic [16:0]        q_r;
  logic [TOT_W:0]     trial;
  logic               ge;

  // first step compares num itself (quotient bit 16), later steps shift
  assign trial = (cnt_r == 5'd0) ? rem_r : {rem_r[TOT_W-1:0], 1'b0};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == 5'd16) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (TOT_W+1)'(num);
      den_r <= den;
      cnt_r <= 5'd0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (trial - {1'b0, den_r}) : trial;
      q_r   <= {q_r[15:0], ge};
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign busy = busy_r;
  assign quo  = q_r[16] ? 16'hFFFF : q_r[15:0];

endmodule

// ----- rtl/core/tcea_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcea_dp
// Datapath: item registers, track table (valid bits, id/frames memory),
// score memory, decay multiply, totals, divider and output register.
// ----------------------------------------------------------------------------
module tcea_dp #(
  parameter int MAX_TRACKS = tcea_pkg::MAX_TRACKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcea_pkg::dp_cmd_t   cmd,
  output tcea_pkg::dp_stat_t  st,
  input  logic [2:0]          item_command,
  input  logic [15:0]         item_obj_id,
  input  logic [1:0]          item_head,
  input  logic [3:0]          item_element_index,
  input  logic [15:0]         item_prob,
  input  logic [3:0]          item_count,
  input  logic [15:0]         decay,
  input  logic [15:0]         min_frames,
  input  logic                res_ready,
  output logic                res_valid,
  output tcea_pkg::res_t      res
);
  import tcea_pkg::*;

  localparam int SW     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int IW     = (SW > 5) ? SW : 5;
  localparam int SDEPTH = MAX_TRACKS * HEAD_SLOTS;
  localparam int SAW    = $clog2(SDEPTH);

  // item
  logic [2:0]  op_r;
  logic [15:0] id_r;
  logic [1:0]  head_r;
  logic [3:0]  elem_r;
  logic [15:0] prob_r;
  logic [3:0]  count_r;

  // table
  logic [MAX_TRACKS-1:0] valid_r;
  logic [31:0]           meta_mem [MAX_TRACKS];   // {id, frames}
  logic [31:0]           meta_q_r;
  logic [SCORE_W-1:0]    score_mem [SDEPTH];
  logic [SCORE_W-1:0]    sc_q_r;

  logic [SW-1:0] slot_r;
  logic [SW-1:0] add_slot_r;
  logic [SW-1:0] free_slot_r;
  logic          free_found_r;
  logic          rm_hit_r;
  logic [IW-1:0] i_r;
  logic [3:0]    k_r;
  logic          first_r;
  logic [15:0]   frames_r;
  logic [PROD_W-1:0]  prod_r;
  logic [TOT_W-1:0]   total_r;
  logic [SCORE_W-1:0] best_r;
  logic [3:0]         best_idx_r;

  logic          out_valid_r;
  res_t          res_r;
  res_t          res_nxt;

  logic [SW-1:0]      i_slot;
  logic [3:0]         cap;
  logic [3:0]         m_cnt;
  logic [SAW-1:0]     slot_base;
  logic [SAW-1:0]     sc_addr;
  logic [SAW-1:0]     clr_addr;
  logic               hit;
  logic [15:0]        p_add;
  logic [32:0]        upd_sum;
  logic [SCORE_W-1:0] upd_val;
  logic [15:0]        frames_inc;
  logic [SW-1:0]      meta_raddr;
  logic               meta_we;
  logic [SW-1:0]      meta_waddr;
  logic [31:0]        meta_wdata;
  logic               div_busy;
  logic [15:0]        div_q;
  logic               is_track;

  assign i_slot    = i_r[SW-1:0];
  assign cap       = head_size(head_r);
  assign m_cnt     = (count_r < cap) ? count_r : cap;
  assign slot_base = SAW'(slot_r) * SAW'(HEAD_SLOTS);
  assign sc_addr   = slot_base + SAW'(head_base(head_r)) + SAW'(k_r);
  assign clr_addr  = slot_base + SAW'(i_r[4:0]);
  assign hit       = valid_r[i_slot] && (meta_q_r[31:16] == id_r);

  assign p_add   = first_r ? prob_r : 16'd0;
  assign upd_sum = {1'b0, prod_r[47:16]} + 33'(p_add);
  assign upd_val = upd_sum[32] ? {SCORE_W{1'b1}} : upd_sum[31:0];

  assign frames_inc = (frames_r == 16'hFFFF) ? frames_r : frames_r + 16'd1;

  assign meta_raddr = cmd.meta_sel_slot ? slot_r : i_slot;
  assign meta_we    = cmd.create || cmd.frames_inc;
  assign meta_waddr = cmd.create ? free_slot_r : slot_r;
  assign meta_wdata = cmd.create ? {id_r, 16'd0} : {id_r, frames_inc};

  tcea_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.div_sel_best ? best_r : sc_q_r),
    .den   (total_r),
    .busy  (div_busy),
    .quo   (div_q)
  );

  // memories
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (cmd.meta_rd) begin
      meta_q_r <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      score_mem[clr_addr] <= '0;
    end else if (cmd.sc_wr) begin
      score_mem[sc_addr] <= upd_val;
    end
    if (cmd.sc_rd) begin
      sc_q_r <= score_mem[sc_addr];
    end
  end

  // control state of the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      add_slot_r <= '0;
    end else begin
      if (cmd.create) begin
        valid_r[free_slot_r] <= 1'b1;
      end
      if (cmd.inval && hit) begin
        valid_r[i_slot] <= 1'b0;
      end
      if (cmd.set_add_slot) begin
        add_slot_r <= slot_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= item_command;
      id_r    <= item_obj_id;
      head_r  <= item_head;
      elem_r  <= item_element_index;
      prob_r  <= item_prob;
      count_r <= item_count;
    end
    if (cmd.idx_clr) begin
      i_r          <= '0;
      free_found_r <= 1'b0;
      rm_hit_r     <= 1'b0;
    end else begin
      if (cmd.idx_inc) begin
        i_r <= i_r + IW'(1);
      end
      if (cmd.cmp_step && !valid_r[i_slot] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= i_slot;
      end
      if (cmd.inval && hit) begin
        rm_hit_r <= 1'b1;
      end
    end
    if (cmd.hit_take) begin
      slot_r   <= i_slot;
      frames_r <= meta_q_r[15:0];
    end else if (cmd.create) begin
      slot_r   <= free_slot_r;
      frames_r <= 16'd0;
    end else if (cmd.use_add_slot) begin
      slot_r <= add_slot_r;
    end else if (cmd.take_frames) begin
      frames_r <= meta_q_r[15:0];
    end else if (cmd.frames_inc) begin
      frames_r <= frames_inc;
    end
    if (cmd.k_init_elem) begin
      k_r     <= elem_r;
      first_r <= 1'b1;
    end else if (cmd.k_clr) begin
      k_r <= 4'd0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + 4'd1;
    end
    if (cmd.sc_wr) begin
      first_r <= 1'b0;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(sc_q_r) * PROD_W'(decay);
    end
    if (cmd.acc_clr) begin
      total_r    <= '0;
      best_r     <= '0;
      best_idx_r <= 4'd0;
    end else if (cmd.acc_step) begin
      total_r <= total_r + TOT_W'(sc_q_r);
      if (sc_q_r > best_r) begin
        best_r     <= sc_q_r;
        best_idx_r <= k_r;
      end
    end
  end

  // result
  always_comb begin
    is_track            = cmd.out_kind != KIND_NONE;
    res_nxt.status      = cmd.out_status;
    res_nxt.frames      = is_track ? frames_r : 16'd0;
    res_nxt.stable      = is_track && (frames_r >= min_frames);
    res_nxt.best_index  = (cmd.out_kind == KIND_VERD) ? best_idx_r : 4'd0;
    res_nxt.confidence  = (cmd.out_kind == KIND_VERD) ? div_q : 16'd0;
    res_nxt.class_index = (cmd.out_kind == KIND_SHARE) ? k_r : 4'd0;
    res_nxt.share       = (cmd.out_kind == KIND_SHARE) ? div_q : 16'd0;
    res_nxt.last_result = (cmd.out_kind == KIND_SHARE) ? (k_r == m_cnt - 4'd1) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

  // status
  always_comb begin
    st.op          = op_r;
    st.add_noop    = (count_r == 4'd0) || (elem_r >= count_r);
    st.elem0       = elem_r == 4'd0;
    st.elem_lt_cap = elem_r < cap;
    st.sh_cnt_zero = count_r == 4'd0;
    st.i_last      = i_r == IW'(MAX_TRACKS - 1);
    st.clr_last    = i_r == IW'(HEAD_SLOTS - 1);
    st.hit         = hit;
    st.free_any    = free_found_r || !valid_r[i_slot];
    st.slot_ok     = valid_r[slot_r] && (meta_q_r[31:16] == id_r);
    st.k_cont      = (elem_r == count_r - 4'd1) && (({1'b0, k_r} + 5'd1) < {1'b0, cap});
    st.sum_last    = k_r == cap - 4'd1;
    st.total_zero  = total_r == '0;
    st.sh_last     = k_r == m_cnt - 4'd1;
    st.div_busy    = div_busy;
    // only sampled on the last compare of a remove
    st.rm_any      = rm_hit_r || hit;
    st.out_free    = !out_valid_r || res_ready;
  end

endmodule

// ----- rtl/core/tcea_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcea_ctrl
// Sequencer: table search, entry creation and clear, score update loop,
// sum/argmax pass, divides and result emission.
// ----------------------------------------------------------------------------
module tcea_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  tcea_pkg::dp_stat_t st,
  output tcea_pkg::dp_cmd_t  cmd
);
  import tcea_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_SRD    = 5'd2;
  localparam logic [4:0] S_SCMP   = 5'd3;
  localparam logic [4:0] S_CREATE = 5'd4;
  localparam logic [4:0] S_CLR    = 5'd5;
  localparam logic [4:0] S_ADDSET = 5'd6;
  localparam logic [4:0] S_ACHK1  = 5'd7;
  localparam logic [4:0] S_ACHK2  = 5'd8;
  localparam logic [4:0] S_URD    = 5'd9;
  localparam logic [4:0] S_UMUL   = 5'd10;
  localparam logic [4:0] S_UWR    = 5'd11;
  localparam logic [4:0] S_BUMP   = 5'd12;
  localparam logic [4:0] S_SUMRD  = 5'd13;
  localparam logic [4:0] S_SUMACC = 5'd14;
  localparam logic [4:0] S_SUMCHK = 5'd15;
  localparam logic [4:0] S_DIVW   = 5'd16;
  localparam logic [4:0] S_SHRD   = 5'd17;
  localparam logic [4:0] S_SHDIV  = 5'd18;
  localparam logic [4:0] S_SHW    = 5'd19;
  localparam logic [4:0] S_EMIT   = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [1:0] em_status_r, em_status_nxt;
  logic [1:0] em_kind_r, em_kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      em_status_r <= ST_OK;
      em_kind_r   <= KIND_NONE;
    end else begin
      state_r     <= state_nxt;
      em_status_r <= em_status_nxt;
      em_kind_r   <= em_kind_nxt;
    end
  end

  assign item_ready = state_r == S_IDLE;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    em_status_nxt = em_status_r;
    em_kind_nxt   = em_kind_r;
    cmd.out_status = em_status_r;
    cmd.out_kind   = em_kind_r;
    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (st.op)
          CMD_ADD: begin
            if (st.add_noop) begin
              em_status_nxt = ST_OK;
              em_kind_nxt   = KIND_NONE;
              state_nxt     = S_EMIT;
            end else if (st.elem0) begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_SRD;
            end else begin
              cmd.use_add_slot = 1'b1;
              state_nxt        = S_ACHK1;
            end
          end
          CMD_BUMP, CMD_VERD, CMD_REMOVE: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_SRD;
          end
          CMD_SHARES: begin
            if (st.sh_cnt_zero) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_SRD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SRD: begin
        cmd.meta_rd = 1'b1;
        state_nxt   = S_SCMP;
      end
      S_SCMP: begin
        cmd.cmp_step = 1'b1;
        if (st.op == CMD_REMOVE) begin
          cmd.inval = 1'b1;
          if (st.i_last) begin
            em_status_nxt = st.rm_any ? ST_OK : ST_NOTFOUND;
            em_kind_nxt   = KIND_NONE;
            state_nxt     = S_EMIT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_SRD;
          end
        end else if (st.hit) begin
          cmd.hit_take = 1'b1;
          if (st.op == CMD_ADD) begin
            state_nxt = S_ADDSET;
          end else if (st.op == CMD_BUMP) begin
            state_nxt = S_BUMP;
          end else begin
            cmd.k_clr   = 1'b1;
            cmd.acc_clr = 1'b1;
            state_nxt   = S_SUMRD;
          end
        end else if (st.i_last) begin
          if (st.op == CMD_ADD || st.op == CMD_BUMP) begin
            if (st.free_any) begin
              state_nxt = S_CREATE;
            end else begin
              em_status_nxt = ST_FULL;
              em_kind_nxt   = KIND_NONE;
              state_nxt     = S_EMIT;
            end
          end else begin
            em_status_nxt = ST_NOTFOUND;
            em_kind_nxt   = KIND_NONE;
            state_nxt     = S_EMIT;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_CREATE: begin
        cmd.create  = 1'b1;
        cmd.idx_clr = 1'b1;
        state_nxt   = S_CLR;
      end
      S_CLR: begin
        // zero the new track's 26 scores
        cmd.clr_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (st.clr_last) begin
          state_nxt = (st.op == CMD_ADD) ? S_ADDSET : S_BUMP;
        end
      end
      S_ADDSET: begin
        cmd.set_add_slot = 1'b1;
        if (st.elem_lt_cap) begin
          cmd.k_init_elem = 1'b1;
          state_nxt       = S_URD;
        end else begin
          em_status_nxt = ST_OK;
          em_kind_nxt   = KIND_TRACK;
          state_nxt     = S_EMIT;
        end
      end
      S_ACHK1: begin
        cmd.meta_rd       = 1'b1;
        cmd.meta_sel_slot = 1'b1;
        state_nxt         = S_ACHK2;
      end
      S_ACHK2: begin
        if (st.slot_ok) begin
          cmd.take_frames = 1'b1;
          if (st.elem_lt_cap) begin
            cmd.k_init_elem = 1'b1;
            state_nxt       = S_URD;
          end else begin
            em_status_nxt = ST_OK;
            em_kind_nxt   = KIND_TRACK;
            state_nxt     = S_EMIT;
          end
        end else begin
          em_status_nxt = ST_NOTFOUND;
          em_kind_nxt   = KIND_NONE;
          state_nxt     = S_EMIT;
        end
      end
      S_URD: begin
        cmd.sc_rd = 1'b1;
        state_nxt = S_UMUL;
      end
      S_UMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UWR;
      end
      S_UWR: begin
        cmd.sc_wr = 1'b1;
        if (st.k_cont) begin
          cmd.k_inc = 1'b1;
          state_nxt = S_URD;
        end else begin
          em_status_nxt = ST_OK;
          em_kind_nxt   = KIND_TRACK;
          state_nxt     = S_EMIT;
        end
      end
      S_BUMP: begin
        cmd.frames_inc = 1'b1;
        em_status_nxt  = ST_OK;
        em_kind_nxt    = KIND_TRACK;
        state_nxt      = S_EMIT;
      end
      S_SUMRD: begin
        cmd.sc_rd = 1'b1;
        state_nxt = S_SUMACC;
      end
      S_SUMACC: begin
        cmd.acc_step = 1'b1;
        if (st.sum_last) begin
          state_nxt = S_SUMCHK;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_SUMRD;
        end
      end
      S_SUMCHK: begin
        if (st.total_zero) begin
          em_status_nxt = ST_NOEV;
          em_kind_nxt   = KIND_TRACK;
          state_nxt     = S_EMIT;
        end else if (st.op == CMD_VERD) begin
          cmd.div_start    = 1'b1;
          cmd.div_sel_best = 1'b1;
          state_nxt        = S_DIVW;
        end else begin
          cmd.k_clr = 1'b1;
          state_nxt = S_SHRD;
        end
      end
      S_DIVW: begin
        if (!st.div_busy) begin
          em_status_nxt = ST_OK;
          em_kind_nxt   = KIND_VERD;
          state_nxt     = S_EMIT;
        end
      end
      S_SHRD: begin
        cmd.sc_rd = 1'b1;
        state_nxt = S_SHDIV;
      end
      S_SHDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_SHW;
      end
      S_SHW: begin
        if (!st.div_busy) begin
          em_status_nxt = ST_OK;
          em_kind_nxt   = KIND_SHARE;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (em_kind_r == KIND_SHARE && !st.sh_last) begin
            cmd.k_inc = 1'b1;
            state_nxt = S_SHRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/track_class_evidence_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_class_evidence_accumulator
// Per-track decaying class score table with verdict and share queries.
// ----------------------------------------------------------------------------
// Usage: commands arrive on in_ch (valid/ready); each command item yields
// results on out_ch (valid/ready), last_result marking the final one. A
// shares query yields up to nine results; unused commands and shares with
// count zero yield none. decay and the min-frames threshold are written
// through the APB-style cfg_ port (byte addresses 0 and 4) while idle.
// Timing: one item at a time. Table search reads and compares the stored
// ids one after another; creating a track then zeroes its 26 scores. An
// add updates each score it touches by read, multiply and write, a verdict
// sums every class of the head before one divide, and a shares query sums
// every class and then reads, divides and emits once per share.
// The result sits in an output register: in_ch.ready returns as soon as the
// last result is loaded, even if out_ch stalls; a stall only holds the block
// when a further result must be loaded. Reset empties the table and
// restores the register defaults.
// ----------------------------------------------------------------------------
module track_class_evidence_accumulator #(
  parameter int MAX_TRACKS = tcea_pkg::MAX_TRACKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tcea_in_if.sink     in_ch,
  tcea_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tcea_pkg::*;

  logic [15:0] decay_r;
  logic [15:0] minf_r;
  logic        cfg_we;
  dp_cmd_t     cmd;
  dp_stat_t    st;
  res_t        res;
  logic        res_valid;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_RST;
      minf_r  <= MINF_RST;
    end else if (cfg_we) begin
      case (cfg_paddr[2])
        REG_DECAY: decay_r <= cfg_pwdata[15:0];
        REG_MINF:  minf_r  <= cfg_pwdata[15:0];
        default:   decay_r <= decay_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_DECAY: cfg_prdata = {16'd0, decay_r};
      REG_MINF:  cfg_prdata = {16'd0, minf_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  tcea_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_ch.valid),
    .item_ready (in_ch.ready),
    .st         (st),
    .cmd        (cmd)
  );

  tcea_dp #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .item_command       (in_ch.command),
    .item_obj_id        (in_ch.obj_id),
    .item_head          (in_ch.head),
    .item_element_index (in_ch.element_index),
    .item_prob          (in_ch.prob),
    .item_count         (in_ch.count),
    .decay              (decay_r),
    .min_frames         (minf_r),
    .res_ready          (out_ch.ready),
    .res_valid          (res_valid),
    .res                (res)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.status      = res.status;
  assign out_ch.frames      = res.frames;
  assign out_ch.stable      = res.stable;
  assign out_ch.best_index  = res.best_index;
  assign out_ch.confidence  = res.confidence;
  assign out_ch.class_index = res.class_index;
  assign out_ch.share       = res.share;
  assign out_ch.last_result = res.last_result;

endmodule

// ----- rtl/core/tcea_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcea_chk
// Port-level checks for the evidence accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module tcea_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_last,
  input logic [15:0] out_share
);
  import tcea_pkg::*;

  // reset leaves no result pending and the input open
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // one item at a time: accepting closes the input for the next cycle
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");

  // only shares results are non-final, and they carry status ok
  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_OK))
    else $error("non-final result with error status");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_share) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind track_class_evidence_accumulator tcea_chk u_tcea_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_last   (out_ch.last_result),
  .out_share  (out_ch.share)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the track class evidence accumulator: a directed
// burst over every command and corner case, then random add sequences,
// bumps, queries and removes over a small id pool with table overflow, each
// result checked against an in-bench score table predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import tcea_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  tcea_in_if  in_ch();
  tcea_out_if out_ch();

  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  track_class_evidence_accumulator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] obj_id;
    logic [1:0]  head;
    logic [3:0]  element_index;
    logic [15:0] prob;
    logic [3:0]  count;
  } cmd_item_t;

  localparam int NT = MAX_TRACKS_DEF;

  // predictor state
  logic [15:0] m_decay, m_minf;
  logic        t_valid [NT];
  logic [15:0] t_id    [NT];
  logic [15:0] t_frames[NT];
  logic [31:0] t_score [NT][HEAD_SLOTS];
  int          add_slot;

  cmd_item_t pending_cmds[$];
  res_t      expected_results[$];
  int        errors = 0, n_results = 0, n_sent = 0;
  int        in_idle_pct = 6, out_idle_pct = 52;
  logic      hold_in = 1'b0;

  function automatic int hsize(logic [1:0] h);
    case (h)
      2'd0: return 7;
      2'd1: return 2;
      2'd2: return 9;
      default: return 8;
    endcase
  endfunction

  function automatic int hbase(logic [1:0] h);
    case (h)
      2'd0: return 0;
      2'd1: return 7;
      2'd2: return 9;
      default: return 18;
    endcase
  endfunction

  function automatic logic [31:0] decayed(logic [31:0] s, logic [15:0] p);
    logic [63:0] v;
    v = ((64'(s) * 64'(m_decay)) >> 16) + 64'(p);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [15:0] share_of(logic [31:0] num, logic [63:0] total);
    logic [63:0] q;
    q = (64'(num) << 16) / total;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic int find_track(logic [15:0] id);
    for (int i = 0; i < NT; i++)
      if (t_valid[i] && t_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_or_open(logic [15:0] id);
    int s;
    s = find_track(id);
    if (s >= 0) return s;
    for (int i = 0; i < NT; i++)
      if (!t_valid[i]) begin
        t_valid[i] = 1'b1;
        t_id[i] = id;
        t_frames[i] = '0;
        for (int k = 0; k < HEAD_SLOTS; k++) t_score[i][k] = '0;
        return i;
      end
    return -1;
  endfunction

  function automatic res_t track_res(logic [1:0] st, int s);
    res_t r;
    r = '0;
    r.status = st;
    r.last_result = 1'b1;
    if (s >= 0) begin
      r.frames = t_frames[s];
      r.stable = t_frames[s] >= m_minf;
    end
    return r;
  endfunction

  function automatic void queue_result(res_t r);
    expected_results = {expected_results, r};
  endfunction

  task automatic predict_results(cmd_item_t c);
    int s, cap, b, best;
    logic [31:0] bestv;
    logic [63:0] total;
    res_t r;
    cap = hsize(c.head);
    b = hbase(c.head);
    case (c.command)
      CMD_ADD: begin
        if (c.count == 0 || c.element_index >= c.count) begin
          queue_result(track_res(ST_OK, -1));
          return;
        end
        if (c.element_index == 0) begin
          s = find_or_open(c.obj_id);
          if (s < 0) begin
            queue_result(track_res(ST_FULL, -1));
            return;
          end
          add_slot = s;
        end else begin
          s = add_slot;
          if (!t_valid[s] || t_id[s] != c.obj_id) begin
            queue_result(track_res(ST_NOTFOUND, -1));
            return;
          end
        end
        if (c.element_index < cap)
          t_score[s][b + c.element_index] = decayed(t_score[s][b + c.element_index], c.prob);
        if (c.element_index == c.count - 1)
          for (int i = c.count; i < cap; i++) t_score[s][b + i] = decayed(t_score[s][b + i], 0);
        queue_result(track_res(ST_OK, s));
      end
      CMD_BUMP: begin
        s = find_or_open(c.obj_id);
        if (s < 0) begin
          queue_result(track_res(ST_FULL, -1));
          return;
        end
        if (t_frames[s] != 16'hFFFF) t_frames[s]++;
        queue_result(track_res(ST_OK, s));
      end
      CMD_VERD, CMD_SHARES: begin
        if (c.command == CMD_SHARES && c.count == 0) return;
        s = find_track(c.obj_id);
        if (s < 0) begin
          queue_result(track_res(ST_NOTFOUND, -1));
          return;
        end
        total = '0;
        best = -1;
        bestv = '0;
        for (int i = 0; i < cap; i++) begin
          total += 64'(t_score[s][b + i]);
          if (t_score[s][b + i] > bestv) begin
            bestv = t_score[s][b + i];
            best = i;
          end
        end
        if (best < 0 || total == 0) begin
          queue_result(track_res(ST_NOEV, s));
          return;
        end
        if (c.command == CMD_VERD) begin
          r = track_res(ST_OK, s);
          r.best_index = best[3:0];
          r.confidence = share_of(bestv, total);
          queue_result(r);
          return;
        end
        for (int i = 0; i < ((c.count < cap) ? c.count : cap); i++) begin
          r = track_res(ST_OK, s);
          r.class_index = i[3:0];
          r.share = share_of(t_score[s][b + i], total);
          r.last_result = (i == ((c.count < cap) ? c.count : cap) - 1);
          queue_result(r);
        end
      end
      CMD_REMOVE: begin
        b = 0;
        for (int i = 0; i < NT; i++)
          if (t_valid[i] && t_id[i] == c.obj_id) begin
            t_valid[i] = 1'b0;
            b = 1;
          end
        queue_result(track_res(b ? ST_OK : ST_NOTFOUND, -1));
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        predict_results({in_ch.command, in_ch.obj_id, in_ch.head,
                         in_ch.element_index, in_ch.prob, in_ch.count});
        n_sent++;
      end
      if (pending_cmds.size() > 0 && !hold_in && $urandom_range(99) >= in_idle_pct) begin
        {in_ch.command, in_ch.obj_id, in_ch.head, in_ch.element_index,
         in_ch.prob, in_ch.count} <= pending_cmds.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.frames, out_ch.stable, out_ch.best_index,
               out_ch.confidence, out_ch.class_index, out_ch.share, out_ch.last_result};
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // watchdog: no handshake on either channel for too long
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("track_class_evidence_accumulator verification failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [15:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr[2] == REG_DECAY) m_decay = val;
    else m_minf = val;
  endtask

  task automatic push(logic [2:0] c, logic [15:0] id, logic [1:0] h,
                      logic [3:0] e, logic [15:0] p, logic [3:0] n);
    cmd_item_t item;
    item = {c, id, h, e, p, n};
    pending_cmds = {pending_cmds, item};
  endtask

  // full add sequence for one head, random probabilities
  task automatic push_add_seq(logic [15:0] id, logic [1:0] h, logic [3:0] n);
    for (int e = 0; e < n; e++) push(CMD_ADD, id, h, e[3:0], 16'($urandom), n);
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
  endfunction

  task automatic random_phase(int n);
    int k;
    logic [1:0] h;
    k = 0;
    while (k < n) begin
      h = 2'($urandom_range(3));
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          push_add_seq(pick_id(), h, 4'($urandom_range(1, 10)));
          k += 5;
        end
        8, 9, 10: push(CMD_BUMP, pick_id(), h, 0, 0, 0);
        11, 12: push(CMD_VERD, pick_id(), h, 4'($urandom), 16'($urandom), 4'($urandom));
        13, 14: push(CMD_SHARES, pick_id(), h, 4'($urandom), 16'($urandom),
                     4'($urandom_range(15)));
        15: push(CMD_REMOVE, pick_id(), h, 0, 0, 0);
        default: push(3'($urandom_range(7)), 16'($urandom), h, 4'($urandom),
                      16'($urandom), 4'($urandom));
      endcase
      k++;
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0; in_ch.obj_id = '0; in_ch.head = '0;
    in_ch.element_index = '0; in_ch.prob = '0; in_ch.count = '0;
    out_ch.ready = 1'b0;
    m_decay = DECAY_RST;
    m_minf = MINF_RST;
    add_slot = 0;
    for (int i = 0; i < NT; i++) t_valid[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: misses, no evidence, extremes, broken adds, bad opcodes
    push(CMD_VERD, 16'd5, 2'd0, 0, 0, 0);
    push(CMD_SHARES, 16'd5, 2'd0, 0, 0, 4'd3);
    push(CMD_REMOVE, 16'd5, 2'd0, 0, 0, 0);
    push(CMD_BUMP, 16'hFFFF, 2'd1, 0, 0, 0);
    push(CMD_VERD, 16'hFFFF, 2'd1, 0, 0, 0);
    push(CMD_ADD, 16'hFFFF, 2'd2, 4'd0, 16'hFFFF, 4'd15);
    push(CMD_ADD, 16'hFFFF, 2'd2, 4'd14, 16'hFFFF, 4'd15);
    push(CMD_ADD, 16'd0, 2'd3, 4'd0, 16'h0, 4'd0);
    push(CMD_ADD, 16'd0, 2'd3, 4'd5, 16'h1234, 4'd2);
    push(CMD_ADD, 16'd7, 2'd3, 4'd1, 16'h1234, 4'd2);
    push(CMD_ADD, 16'd0, 2'd3, 4'd0, 16'h0, 4'd1);
    push(CMD_SHARES, 16'd0, 2'd3, 0, 0, 4'd15);
    push(CMD_VERD, 16'hFFFF, 2'd2, 0, 0, 0);
    push(CMD_SHARES, 16'hFFFF, 2'd2, 0, 0, 4'd15);
    push(CMD_SHARES, 16'hFFFF, 2'd2, 0, 0, 4'd0);
    push(3'd5, 16'd1, 0, 0, 0, 0);
    push(3'd7, 16'd1, 0, 0, 0, 0);
    push(CMD_REMOVE, 16'hFFFF, 2'd0, 0, 0, 0);
    push(CMD_ADD, 16'hFFFF, 2'd2, 4'd1, 16'h1, 4'd3);
    drain();
    cfg_write(3'd0, 16'hFFFF);
    cfg_write(3'd4, 16'd0);
    // saturate scores with full decay
    for (int r = 0; r < 3; r++) push_add_seq(16'd9, 2'd1, 4'd2);
    for (int r = 0; r < 3; r++) push(CMD_ADD, 16'd9, 2'd1, 0, 16'hFFFF, 4'd1);
    push(CMD_VERD, 16'd9, 2'd1, 0, 0, 0);
    // fill the table past capacity
    for (int i = 0; i < NT + 2; i++) push(CMD_BUMP, 16'(100 + i), 2'd0, 0, 0, 0);
    push(CMD_ADD, 16'd999, 2'd0, 0, 16'd5, 4'd1);
    for (int i = 0; i < NT + 2; i++) push(CMD_REMOVE, 16'(100 + i), 2'd0, 0, 0, 0);
    random_phase(120);
    drain();

    cfg_write(3'd0, 16'd0);
    cfg_write(3'd4, 16'hFFFF);
    in_idle_pct = 52; out_idle_pct = 6;
    random_phase(120);
    // pause mid-stream until every outstanding result is back
    wait (pending_cmds.size() < 60);
    hold_in = 1'b1;
    wait (pending_cmds.size() > 0 && !in_ch.valid && expected_results.size() == 0);
    hold_in = 1'b0;
    drain();

    cfg_write(3'd0, 16'($urandom));
    cfg_write(3'd4, 16'($urandom_range(6)));
    in_idle_pct = 0; out_idle_pct = 0;
    random_phase(120);
    drain();

    $display("Ran %0d items, %0d results: adds, bumps, verdicts, shares, removes,",
             n_sent, n_results);
    $display("table overflow and decay/min-frames extremes.");
    if (errors == 0) begin
      $display("track_class_evidence_accumulator verification clean");
    end else begin
      $display("track_class_evidence_accumulator verification failed");
    end
    $finish;
  end
endmodule
